/* src/mlpd_pkg.sv */
// mlpd_pkg: shared types, codes and the tanh table for the dense forward block
// no dependencies; imported by mlp_dense_forward

package mlpd_pkg;

   localparam int LAYER_WORDS = 1024;
   localparam int LAYER_IDX_W = 10;
   localparam int VALUE_W     = 16;
   localparam int ACC_W       = 40;
   localparam int PROD_W      = 32;
   localparam int RESULT_CAP  = 32;

   typedef enum logic [1:0] {
      OP_WEIGHT  = 2'd0,
      OP_BIAS    = 2'd1,
      OP_FEATURE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ACT_LINEAR     = 2'd0,
      ACT_RELU       = 2'd1,
      ACT_TANH       = 2'd2,
      ACT_LINEAR_ALT = 2'd3
   } act_type;

   typedef enum logic [2:0] {
      CSR_LAYER_COUNT = 3'd0,
      CSR_WIDTH_0     = 3'd1,
      CSR_WIDTH_1     = 3'd2,
      CSR_WIDTH_2     = 3'd3,
      CSR_WIDTH_3     = 3'd4,
      CSR_WIDTH_4     = 3'd5,
      CSR_ACT_CODES   = 3'd6,
      CSR_SPARE       = 3'd7
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BIAS_RD,
      ST_BIAS_LD,
      ST_MAC,
      ST_ROUND,
      ST_ACT,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_HOLD
   } state_type;

   // round(256 * tanh(k / 8)) for k = 0..32
   function automatic logic [8:0] tanh_point(input logic [5:0] k);
      logic [8:0] p;
      case (k)
         6'd0:  p = 9'd0;    6'd1:  p = 9'd32;   6'd2:  p = 9'd63;   6'd3:  p = 9'd92;
         6'd4:  p = 9'd118;  6'd5:  p = 9'd142;  6'd6:  p = 9'd163;  6'd7:  p = 9'd180;
         6'd8:  p = 9'd195;  6'd9:  p = 9'd207;  6'd10: p = 9'd217;  6'd11: p = 9'd225;
         6'd12: p = 9'd232;  6'd13: p = 9'd237;  6'd14: p = 9'd241;  6'd15: p = 9'd244;
         6'd16: p = 9'd247;  6'd17: p = 9'd249;  6'd18: p = 9'd250;  6'd19: p = 9'd252;
         6'd20: p = 9'd253;  6'd21: p = 9'd253;  6'd22: p = 9'd254;  6'd23: p = 9'd254;
         6'd24: p = 9'd255;  6'd25: p = 9'd255;  6'd26: p = 9'd255;  6'd27: p = 9'd255;
         default: p = 9'd256;
      endcase
      return p;
   endfunction

   // odd symmetric piecewise linear tanh in Q8.8, saturating at |x| >= 4.0
   function automatic logic signed [15:0] tanh_q(input logic signed [15:0] x);
      logic [15:0] mag;
      logic [5:0]  seg;
      logic [4:0]  frac;
      logic [8:0]  p0;
      logic [8:0]  p1;
      logic [10:0] slope;
      logic [8:0]  y;
      mag   = x[15] ? 16'(-x) : x;
      seg   = {1'b0, mag[9:5]};
      frac  = mag[4:0];
      p0    = tanh_point(seg);
      p1    = tanh_point(seg + 6'd1);
      slope = 11'((p1 - p0) * frac) + 11'd16;
      y     = (mag >= 16'd1024) ? 9'd256 : p0 + 9'(slope[10:5]);
      return x[15] ? -$signed({7'd0, y}) : $signed({7'd0, y});
   endfunction

endpackage

/* src/mlpd_ram.sv */
// mlpd_ram: generic single write, single read memory with registered read data
// no dependencies; used for the weight, bias and activation stores

module mlpd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mlp_dense_forward.sv */
// mlp_dense_forward: fixed-point dense network inference around one shared multiply-accumulate
// depends on mlpd_pkg and mlpd_ram

// Load items (weight, bias) and feature items arrive on the req_ stream; each is taken while
// the block is idle. A feature transfer with tlast set starts a forward pass and the block
// drops req_tready until the last result has been taken. Per row the sequencer reads the bias,
// runs the pipelined multiply-accumulate (memory read, multiply, accumulate) on the single
// 16x16 multiplier, then rounds and applies the activation. Each result is then read from the
// activation store, loaded into the output register and held until rsp_tready takes it.
// Results are Q8.8, rounded half up and saturated; tanh uses a 33 point interpolated table.
// Stores hold garbage until written and must be loaded before use. The user must write
// configuration only while the block is idle; the block itself does not enforce this.

module mlp_dense_forward #(
   parameter int MAX_WIDTH  = 32,
   parameter int MAX_LAYERS = 4
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // layer [1:0], index [11:2], value [27:12], zero fill
   input  logic [1:0]  req_tuser,   // operation
   input  logic        req_tlast,   // last feature, starts the pass
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // value_res [15:0], index_res [20:16], zero fill
   output logic        rsp_tlast,   // final result of the pass
   // register writes
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   import mlpd_pkg::*;

   localparam int AW      = $clog2(MAX_WIDTH);
   localparam int CW      = $clog2(MAX_WIDTH + 1);
   localparam int WAW     = $clog2(MAX_LAYERS * LAYER_WORDS);
   localparam int BAW     = $clog2(MAX_LAYERS * MAX_WIDTH);
   localparam int OUT_CAP = (MAX_WIDTH < RESULT_CAP) ? MAX_WIDTH : RESULT_CAP;

   // configuration registers
   logic [2:0] layer_count_ff;
   logic [5:0] width_ff [5];
   logic [7:0] act_codes_ff;

   // sequencer state
   state_type               state_ff, state_in;
   logic [2:0]              layer_ff, layer_in;
   logic [CW-1:0]           row_ff, row_in;
   logic [LAYER_IDX_W-1:0]  base_ff, base_in;
   logic [CW-1:0]           col_ff, col_in;
   logic                    s1_ff, s1_in;
   logic                    s2_ff, s2_in;
   logic                    sel_ff, sel_in;   // 0: source is buffer a
   logic [CW-1:0]           k_ff, k_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_last_ff, rsp_last_in;

   // datapath registers
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic signed [VALUE_W-1:0] rnd_ff, rnd_in;
   logic [VALUE_W-1:0]        rsp_value_ff, rsp_value_in;
   logic [4:0]                rsp_index_ff, rsp_index_in;

   // input fields
   op_type                   in_op;
   logic [1:0]               in_layer;
   logic [LAYER_IDX_W-1:0]   in_index;
   logic [VALUE_W-1:0]       in_value;
   logic                     req_fire;

   assign in_op    = op_type'(req_tuser);
   assign in_layer = req_tdata[1:0];
   assign in_index = req_tdata[11:2];
   assign in_value = req_tdata[27:12];
   assign req_fire = req_tvalid && req_tready;

   // derived sizes
   function automatic logic [CW-1:0] clamp_width(input logic [5:0] w);
      logic [CW-1:0] r;
      if (w == 6'd0) begin
         r = CW'(1);
      end else if ({1'b0, w} > 7'(MAX_WIDTH)) begin
         r = CW'(MAX_WIDTH);
      end else begin
         r = CW'(w);
      end
      return r;
   endfunction

   logic [2:0]    layers_used;
   logic [CW-1:0] in_w;
   logic [CW-1:0] out_w;
   logic [CW-1:0] out_cnt;
   act_type       layer_act;
   logic [2:0]    next_layer_idx;

   assign next_layer_idx = layer_ff + 3'd1;
   assign layers_used = (layer_count_ff == 3'd0) ? 3'd1 :
                        (layer_count_ff > 3'(MAX_LAYERS)) ? 3'(MAX_LAYERS) : layer_count_ff;
   assign in_w      = clamp_width(width_ff[layer_ff]);
   assign out_w     = clamp_width(width_ff[next_layer_idx]);
   assign out_cnt   = (in_w > CW'(OUT_CAP)) ? CW'(OUT_CAP) : in_w;
   assign layer_act = act_type'(act_codes_ff[{layer_ff[1:0], 1'b0} +: 2]);

   // memories
   logic               w_we, b_we, a_we, bb_we;
   logic [WAW-1:0]     w_waddr, w_raddr;
   logic [BAW-1:0]     b_waddr, b_raddr;
   logic [AW-1:0]      a_waddr, bb_waddr, act_raddr;
   logic [VALUE_W-1:0] a_wdata, bb_wdata;
   logic [VALUE_W-1:0] w_rdata, b_rdata, a_rdata, bb_rdata, src_rdata;
   logic [LAYER_IDX_W-1:0] w_col_addr;
   logic               layer_ok;

   assign layer_ok   = {1'b0, in_layer} < 3'(MAX_LAYERS);
   assign w_col_addr = base_ff + LAYER_IDX_W'(col_ff);
   assign w_waddr    = WAW'({in_layer, in_index});
   assign w_raddr    = WAW'({layer_ff[1:0], w_col_addr});
   assign b_waddr    = BAW'(BAW'(in_layer) * BAW'(MAX_WIDTH) + BAW'(in_index));
   assign b_raddr    = BAW'(BAW'(layer_ff[1:0]) * BAW'(MAX_WIDTH) + BAW'(row_ff));
   assign act_raddr  = (state_ff == ST_MAC) ? col_ff[AW-1:0] : k_ff[AW-1:0];
   assign src_rdata  = sel_ff ? bb_rdata : a_rdata;

   mlpd_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LAYERS * LAYER_WORDS)) u_weight_ram (
      .clock, .wr_en(w_we), .wr_addr(w_waddr), .wr_data(in_value),
      .rd_addr(w_raddr), .rd_data(w_rdata));

   mlpd_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LAYERS * MAX_WIDTH)) u_bias_ram (
      .clock, .wr_en(b_we), .wr_addr(b_waddr), .wr_data(in_value),
      .rd_addr(b_raddr), .rd_data(b_rdata));

   mlpd_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_WIDTH)) u_act_a_ram (
      .clock, .wr_en(a_we), .wr_addr(a_waddr), .wr_data(a_wdata),
      .rd_addr(act_raddr), .rd_data(a_rdata));

   mlpd_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_WIDTH)) u_act_b_ram (
      .clock, .wr_en(bb_we), .wr_addr(bb_waddr), .wr_data(bb_wdata),
      .rd_addr(act_raddr), .rd_data(bb_rdata));

   // rounding and activation
   logic [ACC_W:0]            rnd_sum;
   logic signed [32:0]        rnd_shift;
   logic signed [VALUE_W-1:0] rnd_sat;
   logic signed [VALUE_W-1:0] act_out;
   logic                      mac_issue;
   logic                      mac_done;
   logic                      row_last;
   logic                      pass_last;

   assign rnd_sum   = {acc_ff[ACC_W-1], acc_ff} + (ACC_W+1)'(128);
   assign rnd_shift = $signed(rnd_sum[ACC_W:8]);
   assign rnd_sat   = (rnd_shift > 33'sd32767)  ? 16'sh7FFF :
                      (rnd_shift < -33'sd32768) ? 16'sh8000 : rnd_shift[15:0];

   always_comb begin
      case (layer_act) inside
         ACT_RELU: act_out = rnd_ff[15] ? 16'sd0 : rnd_ff;
         ACT_TANH: act_out = tanh_q(rnd_ff);
         default:  act_out = rnd_ff;
      endcase
   end

   assign mac_issue = (state_ff == ST_MAC) && (col_ff != in_w);
   assign mac_done  = (col_ff == in_w) && !s1_ff && !s2_ff;
   assign row_last  = (row_ff == out_w - CW'(1));
   assign pass_last = (next_layer_idx == layers_used);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && in_op == OP_FEATURE && req_tlast) begin
               state_in = ST_BIAS_RD;
            end
         end
         ST_BIAS_RD:  state_in = ST_BIAS_LD;
         ST_BIAS_LD:  state_in = ST_MAC;
         ST_MAC: begin
            if (mac_done) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND:    state_in = ST_ACT;
         ST_ACT: begin
            state_in = (row_last && pass_last) ? ST_OUT_RD : ST_BIAS_RD;
         end
         ST_OUT_RD:   state_in = ST_OUT_LD;
         ST_OUT_LD:   state_in = ST_OUT_HOLD;
         ST_OUT_HOLD: begin
            if (rsp_tready) begin
               state_in = (k_ff == out_cnt - CW'(1)) ? ST_IDLE : ST_OUT_RD;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      layer_in     = layer_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      col_in       = col_ff;
      s1_in        = mac_issue;
      s2_in        = s1_ff;
      sel_in       = sel_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rnd_in       = rnd_ff;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      w_we         = 1'b0;
      b_we         = 1'b0;
      a_we         = 1'b0;
      bb_we        = 1'b0;
      a_waddr      = in_index[AW-1:0];
      a_wdata      = in_value;
      bb_waddr     = row_ff[AW-1:0];
      bb_wdata     = act_out;

      if (s1_ff) begin
         prod_in = $signed(w_rdata) * $signed(src_rdata);
      end
      if (s2_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            layer_in = 3'd0;
            row_in   = '0;
            base_in  = '0;
            sel_in   = 1'b0;
            k_in     = '0;
            if (req_fire) begin
               w_we = (in_op == OP_WEIGHT) && layer_ok;
               b_we = (in_op == OP_BIAS) && layer_ok && (in_index < LAYER_IDX_W'(MAX_WIDTH));
               a_we = (in_op == OP_FEATURE) && (in_index < LAYER_IDX_W'(MAX_WIDTH));
            end
         end
         ST_BIAS_LD: begin
            acc_in = {{(ACC_W-VALUE_W-8){b_rdata[15]}}, b_rdata, 8'd0};
            col_in = '0;
         end
         ST_MAC: begin
            if (mac_issue) begin
               col_in = col_ff + CW'(1);
            end
         end
         ST_ROUND: rnd_in = rnd_sat;
         ST_ACT: begin
            // destination is the buffer that is not the source
            a_we     = sel_ff;
            a_waddr  = row_ff[AW-1:0];
            a_wdata  = act_out;
            bb_we    = !sel_ff;
            base_in  = base_ff + LAYER_IDX_W'(in_w);
            row_in   = row_ff + CW'(1);
            if (row_last) begin
               layer_in = next_layer_idx;
               sel_in   = !sel_ff;
               row_in   = '0;
               base_in  = '0;
            end
         end
         ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = src_rdata;
            rsp_index_in = k_ff[4:0];
            rsp_last_in  = (k_ff == out_cnt - CW'(1));
         end
         ST_OUT_HOLD: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               k_in         = k_ff + CW'(1);
            end
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         layer_ff       <= 3'd0;
         row_ff         <= '0;
         base_ff        <= '0;
         col_ff         <= '0;
         s1_ff          <= 1'b0;
         s2_ff          <= 1'b0;
         sel_ff         <= 1'b0;
         k_ff           <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_last_ff    <= 1'b0;
         acc_ff         <= '0;
         layer_count_ff <= 3'd1;
         for (int i = 0; i < 5; i++) begin
            width_ff[i] <= 6'd1;
         end
         act_codes_ff   <= 8'd0;
      end else begin
         state_ff     <= state_in;
         layer_ff     <= layer_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         col_ff       <= col_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         sel_ff       <= sel_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         acc_ff       <= acc_in;
         if (csr_we) begin
            unique case (csr_type'(csr_addr))
               CSR_LAYER_COUNT: layer_count_ff <= csr_wdata[2:0];
               CSR_WIDTH_0:     width_ff[0]    <= csr_wdata[5:0];
               CSR_WIDTH_1:     width_ff[1]    <= csr_wdata[5:0];
               CSR_WIDTH_2:     width_ff[2]    <= csr_wdata[5:0];
               CSR_WIDTH_3:     width_ff[3]    <= csr_wdata[5:0];
               CSR_WIDTH_4:     width_ff[4]    <= csr_wdata[5:0];
               CSR_ACT_CODES:   act_codes_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      rnd_ff       <= rnd_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_index_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

   // a result is only offered while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_OUT_HOLD)
      else $error("result valid outside output hold");

   // accumulate stage follows a multiply stage
   assert property (@(posedge clock) disable iff (reset)
      s2_ff |-> $past(s1_ff))
      else $error("accumulate without product");

   // rounding starts only with the multiply-accumulate pipeline drained
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> !s1_ff && !s2_ff && $past(col_ff == in_w))
      else $error("rounding with products in flight");

   // column counter never runs past the input width
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> col_ff <= in_w)
      else $error("column counter overrun");

endmodule
